/* rtl/acr_pkg.sv */
// acr_pkg: shared types, register indexes and a helper function for the
// audio channel reorder block. No dependencies.
package acr_pkg;

    // Fixed field widths
    localparam int SAMPLE_W  = 32;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W   = 4;
    localparam int SLOT_W    = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REMAP_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PASSTHROUGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MAP   = 3'd4;

    // Sample size codes
    localparam logic [2:0] SZ_8  = 3'd0;
    localparam logic [2:0] SZ_16 = 3'd1;
    localparam logic [2:0] SZ_24 = 3'd2;
    localparam logic [2:0] SZ_32 = 3'd3;

    // Reset values
    localparam logic [2:0]         SAMPLE_SIZE_RST   = SZ_16;
    localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST = 4'd2;
    localparam logic [CFG_W-1:0]   CHANNEL_MAP_RST   = 24'hFAC688;  // identity

    // Drain sequencer states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DRAIN
    } acr_state_t;

    // Live configuration, with channel count already clamped
    typedef struct packed {
        logic               remap_enable;
        logic               passthrough;
        logic [2:0]         sample_size;
        logic [CFG_W-1:0]   channel_map;
        logic [COUNT_W-1:0] n;
    } acr_cfg_t;

    // Gather side -> drain side
    typedef struct packed {
        logic                frame_done;
        logic                copy_push;
        logic [SAMPLE_W-1:0] copy_data;
    } acr_cmd_t;

    // Drain side -> gather side
    typedef struct packed {
        logic in_ok;
        logic drain_done;
    } acr_stat_t;

    // Bit mask for a supported sample size code
    function automatic logic [SAMPLE_W-1:0] size_mask(input logic [2:0] sz);
        logic [SAMPLE_W-1:0] m;
        begin
            case (sz)
                SZ_8:    m = 32'h0000_00FF;
                SZ_16:   m = 32'h0000_FFFF;
                SZ_24:   m = 32'h00FF_FFFF;
                default: m = 32'hFFFF_FFFF;
            endcase
            return m;
        end
    endfunction

endpackage

/* rtl/audio_channel_reorder.sv */
// Interleaved audio channel reorder. In copy mode (passthrough set or
// remapping off) each sample goes out in the cycle after its transaction,
// one per clock while the sink keeps up. In remap mode each sample is
// written into the frame store; the sample that completes a frame then
// holds off input while the frame is read back slot 0 first, one slot at a
// time, because the store has one read port with registered read data and
// there is a single output register. Destinations at or above the channel
// count are dropped, slots not written in a frame read as zero, and a
// partial frame at buffer end is lost.
// Depends on acr_pkg, acr_ram, acr_gather, acr_drain.
module audio_channel_reorder #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write port
    input  logic                           cfg_wr_en,
    input  logic [acr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [acr_pkg::CFG_W-1:0]      cfg_wdata,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [acr_pkg::SAMPLE_W-1:0]   s_tdata,   // [31:0] sample
    input  logic                           s_tlast,   // buffer_end
    // Output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [acr_pkg::SAMPLE_W-1:0]   m_tdata,   // [31:0] out_sample
    output logic                           m_tlast    // frame_last
);

    localparam int IDX_W = $clog2(MAX_CHANNELS);

    logic                          remap_enable_reg;
    logic                          passthrough_reg;
    logic [2:0]                    sample_size_reg;
    logic [acr_pkg::COUNT_W-1:0]   channel_count_reg;
    logic [acr_pkg::CFG_W-1:0]     channel_map_reg;

    acr_pkg::acr_cfg_t   cfg;
    acr_pkg::acr_cmd_t   cmd;
    acr_pkg::acr_stat_t  stat;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [SAMPLE_BITS-1:0]  wr_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [SAMPLE_BITS-1:0]  rd_data;
    logic [MAX_CHANNELS-1:0] written;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remap_enable_reg  <= 1'b0;
            passthrough_reg   <= 1'b0;
            sample_size_reg   <= acr_pkg::SAMPLE_SIZE_RST;
            channel_count_reg <= acr_pkg::CHANNEL_COUNT_RST;
            channel_map_reg   <= acr_pkg::CHANNEL_MAP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                acr_pkg::REG_REMAP_ENABLE:  remap_enable_reg  <= cfg_wdata[0];
                acr_pkg::REG_PASSTHROUGH:   passthrough_reg   <= cfg_wdata[0];
                acr_pkg::REG_SAMPLE_SIZE:   sample_size_reg   <= cfg_wdata[2:0];
                acr_pkg::REG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata[3:0];
                acr_pkg::REG_CHANNEL_MAP:   channel_map_reg   <= cfg_wdata;
                default:                    ;
            endcase
        end
    end

    // Live configuration; channel count clamped to 1..MAX_CHANNELS
    always_comb
    begin
        cfg.remap_enable = remap_enable_reg;
        cfg.passthrough  = passthrough_reg;
        cfg.sample_size  = sample_size_reg;
        cfg.channel_map  = channel_map_reg;
        if (channel_count_reg == '0)
        begin
            cfg.n = 4'd1;
        end
        else if (channel_count_reg > acr_pkg::COUNT_W'(MAX_CHANNELS))
        begin
            cfg.n = acr_pkg::COUNT_W'(MAX_CHANNELS);
        end
        else
        begin
            cfg.n = channel_count_reg;
        end
    end

    acr_gather #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_gather (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .written  (written),
        .cmd      (cmd)
    );

    // Frame store
    acr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_CHANNELS)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    acr_drain #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_drain (
        .clk      (clk),
        .rst_n    (rst_n),
        .n        (cfg.n),
        .written  (written),
        .cmd      (cmd),
        .stat     (stat),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/acr_ram.sv */
// acr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module acr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/acr_gather.sv */
// acr_gather: input side. Tracks channel position and written-slot bits,
// issues frame store writes and copy-mode pushes. Depends on acr_pkg.
module acr_gather #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  acr_pkg::acr_cfg_t                 cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [acr_pkg::SAMPLE_W-1:0]      s_tdata,
    input  logic                              s_tlast,
    input  acr_pkg::acr_stat_t                stat,
    output logic                              wr_en,
    output logic [$clog2(MAX_CHANNELS)-1:0]   wr_addr,
    output logic [SAMPLE_BITS-1:0]            wr_data,
    output logic [MAX_CHANNELS-1:0]           written,
    output acr_pkg::acr_cmd_t                 cmd
);

    localparam int IDX_W = $clog2(MAX_CHANNELS);

    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [MAX_CHANNELS-1:0] written_reg, written_next;

    logic                          accept;
    logic                          copy_mode;
    logic                          unsupported;
    logic                          remap_do;
    logic [acr_pkg::SLOT_W-1:0]    pos3;
    logic [4:0]                    map_sel;
    logic [acr_pkg::SLOT_W-1:0]    dest;
    logic                          dest_ok;
    logic                          last;
    logic [SAMPLE_BITS-1:0]        raw;
    logic [acr_pkg::SAMPLE_W-1:0]  smask;

    // Decode of the current transaction
    always_comb
    begin
        accept      = s_tvalid & s_tready;
        copy_mode   = cfg.passthrough | ~cfg.remap_enable;
        unsupported = (cfg.sample_size > acr_pkg::SZ_32);
        remap_do    = accept & ~copy_mode & ~unsupported;
        pos3        = acr_pkg::SLOT_W'(pos_reg);
        map_sel     = {pos3, 1'b0} + 5'(pos3);
        dest        = cfg.channel_map[map_sel +: acr_pkg::SLOT_W];
        dest_ok     = ({1'b0, dest} < cfg.n);
        last        = ((acr_pkg::COUNT_W'(pos3) + 4'd1) >= cfg.n);
        raw         = s_tdata[SAMPLE_BITS-1:0];
        smask       = acr_pkg::size_mask(cfg.sample_size);
    end

    // Frame store write, masked to the configured sample width
    always_comb
    begin
        wr_en   = remap_do & dest_ok;
        wr_addr = dest[IDX_W-1:0];
        wr_data = raw & smask[SAMPLE_BITS-1:0];
    end

    // Position and written-slot next state
    always_comb
    begin
        pos_next     = pos_reg;
        written_next = written_reg;
        if (stat.drain_done)
        begin
            written_next = '0;
        end
        if (accept)
        begin
            if (copy_mode || unsupported)
            begin
                if (s_tlast)
                begin
                    pos_next     = '0;
                    written_next = '0;
                end
            end
            else
            begin
                if (dest_ok)
                begin
                    written_next[dest[IDX_W-1:0]] = 1'b1;
                end
                if (last)
                begin
                    // bits stay for the drain, cleared when it finishes
                    pos_next = '0;
                end
                else if (s_tlast)
                begin
                    // partial frame at buffer end is discarded
                    pos_next     = '0;
                    written_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            written_reg <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            written_reg <= written_next;
        end
    end

    // Handshake and commands to the drain side
    always_comb
    begin
        s_tready       = stat.in_ok;
        written        = written_reg;
        cmd.frame_done = remap_do & last;
        cmd.copy_push  = accept & copy_mode;
        cmd.copy_data  = acr_pkg::SAMPLE_W'(raw);
    end

endmodule

/* rtl/acr_drain.sv */
// acr_drain: output side. Reads the finished frame out of the frame store
// slot by slot and owns the output register. Depends on acr_pkg.
module acr_drain #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [acr_pkg::COUNT_W-1:0]       n,
    input  logic [MAX_CHANNELS-1:0]           written,
    input  acr_pkg::acr_cmd_t                 cmd,
    output acr_pkg::acr_stat_t                stat,
    output logic                              rd_en,
    output logic [$clog2(MAX_CHANNELS)-1:0]   rd_addr,
    input  logic [SAMPLE_BITS-1:0]            rd_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [acr_pkg::SAMPLE_W-1:0]      m_tdata,
    output logic                              m_tlast
);

    localparam int IDX_W = $clog2(MAX_CHANNELS);

    acr_pkg::acr_state_t state_reg, state_next;

    logic [IDX_W-1:0]              slot_reg, slot_next;
    logic                          pend_reg, pend_next;
    logic                          pend_last_reg, pend_last_next;
    logic                          pend_wr_reg, pend_wr_next;
    logic                          out_valid_reg, out_valid_next;
    logic [acr_pkg::SAMPLE_W-1:0]  out_data_reg, out_data_next;
    logic                          out_last_reg, out_last_next;

    logic out_free;
    logic slot_last;
    logic done;

    always_comb
    begin
        out_free  = ~out_valid_reg | m_tready;
        slot_last = ((acr_pkg::COUNT_W'(slot_reg) + 4'd1) == n);
        done      = pend_reg & pend_last_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            acr_pkg::ST_IDLE:
            begin
                if (cmd.frame_done)
                begin
                    state_next = acr_pkg::ST_DRAIN;
                end
            end
            acr_pkg::ST_DRAIN:
            begin
                if (done)
                begin
                    state_next = acr_pkg::ST_IDLE;
                end
            end
            default: state_next = acr_pkg::ST_IDLE;
        endcase
    end

    // State outputs: one read in flight, only when the output register frees
    always_comb
    begin
        rd_en           = 1'b0;
        stat.in_ok      = 1'b0;
        stat.drain_done = 1'b0;
        unique case (state_reg)
            acr_pkg::ST_IDLE:
            begin
                stat.in_ok = out_free;
            end
            acr_pkg::ST_DRAIN:
            begin
                rd_en           = ~pend_reg & out_free;
                stat.drain_done = done;
            end
            default: stat.in_ok = 1'b0;
        endcase
        rd_addr = slot_reg;
    end

    // Slot counter and read-pending tracking
    always_comb
    begin
        slot_next      = slot_reg;
        pend_next      = rd_en;
        pend_last_next = pend_last_reg;
        pend_wr_next   = pend_wr_reg;
        if (rd_en)
        begin
            pend_last_next = slot_last;
            pend_wr_next   = written[slot_reg];
            slot_next      = slot_reg + 1'b1;
        end
        if (done)
        begin
            slot_next = '0;
        end
    end

    // Output register: frame slots and copied samples
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (pend_reg)
        begin
            out_valid_next = 1'b1;
            out_data_next  = pend_wr_reg ? acr_pkg::SAMPLE_W'(rd_data) : '0;
            out_last_next  = pend_last_reg;
        end
        else if (cmd.copy_push)
        begin
            out_valid_next = 1'b1;
            out_data_next  = cmd.copy_data;
            out_last_next  = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= acr_pkg::ST_IDLE;
            slot_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            pend_wr_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            pend_wr_reg   <= pend_wr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        m_tvalid = out_valid_reg;
        m_tdata  = out_data_reg;
        m_tlast  = out_last_reg;
    end

    // Read data never lands on a result still waiting for the sink
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !(out_valid_reg && !m_tready))
        else $error("frame slot would overwrite a pending result");

    // Copy transactions and frame reads never compete for the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !cmd.copy_push)
        else $error("copy push during frame drain");

    // A finished frame always starts a drain
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.frame_done |=> state_reg == acr_pkg::ST_DRAIN)
        else $error("frame completed without drain");

    // Input is held off for the whole drain
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == acr_pkg::ST_DRAIN |-> !stat.in_ok)
        else $error("input open during drain");

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for audio_channel_reorder (copy and remap modes).
// Predicts each accepted sample's output words and compares them in order.
// Depends on acr_pkg and the audio_channel_reorder RTL.
`timescale 1ns / 100ps

module tb;

    localparam int CLK_HALF       = 5;
    localparam int MAX_CH         = 8;
    localparam int DRAIN_GUARD    = 3 * MAX_CH + 4;
    localparam int LONG_STALL     = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    // Sample size code outside the supported set
    localparam logic [2:0] SZ_UNSUPPORTED = 3'd4;

    // Channel maps of the common codec layouts, padded with identity slots
    localparam logic [acr_pkg::CFG_W-1:0] MAP_6CH_A =
        {3'd7, 3'd6, 3'd3, 3'd2, 3'd5, 3'd4, 3'd1, 3'd0};
    localparam logic [acr_pkg::CFG_W-1:0] MAP_6CH_B =
        {3'd7, 3'd6, 3'd3, 3'd5, 3'd4, 3'd1, 3'd2, 3'd0};
    localparam logic [acr_pkg::CFG_W-1:0] MAP_6CH_C =
        {3'd7, 3'd6, 3'd3, 3'd5, 3'd4, 3'd1, 3'd0, 3'd2};
    localparam logic [acr_pkg::CFG_W-1:0] MAP_5CH =
        {3'd7, 3'd6, 3'd5, 3'd3, 3'd2, 3'd4, 3'd1, 3'd0};

    // One output word of the block
    typedef struct packed {
        logic [acr_pkg::SAMPLE_W-1:0] smp;
        logic                         last;
    } out_word_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [acr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [acr_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [acr_pkg::SAMPLE_W-1:0]  s_tdata   = '0;  // [31:0] sample
    logic                          s_tlast   = 1'b0; // buffer_end
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [acr_pkg::SAMPLE_W-1:0]  m_tdata;          // [31:0] out_sample
    logic                          m_tlast;          // frame_last

    // Shadow registers, reset values
    logic                        sh_remap = 1'b0;
    logic                        sh_pass  = 1'b0;
    logic [2:0]                  sh_size  = acr_pkg::SAMPLE_SIZE_RST;
    logic [acr_pkg::COUNT_W-1:0] sh_count = acr_pkg::CHANNEL_COUNT_RST;
    logic [acr_pkg::CFG_W-1:0]   sh_map   = acr_pkg::CHANNEL_MAP_RST;

    // Frame being gathered
    logic [acr_pkg::SAMPLE_W-1:0] frame_slots [MAX_CH];
    logic [MAX_CH-1:0]            slot_filled = '0;
    logic [acr_pkg::SLOT_W-1:0]   chan_pos    = '0;

    out_word_t expected_words [$];
    int        err_count      = 0;
    int        send_idle_pct  = 0;
    int        recv_idle_pct  = 0;
    int        stall_requests = 0;

    audio_channel_reorder #(
        .MAX_CHANNELS (MAX_CH),
        .SAMPLE_BITS  (acr_pkg::SAMPLE_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #CLK_HALF clk = ~clk;

    // Channels per frame after clamping
    function automatic int active_channels();
        int n;
        begin
            n = sh_count;
            if (n == 0)
                n = 1;
            if (n > MAX_CH)
                n = MAX_CH;
            return n;
        end
    endfunction

    function automatic void clear_frame();
        begin
            for (int k = 0; k < MAX_CH; k++)
                frame_slots[k] = '0;
            slot_filled = '0;
            chan_pos    = '0;
        end
    endfunction

    // Expected output words for one accepted input transaction
    function automatic void predict_sample(input logic [acr_pkg::SAMPLE_W-1:0] smp,
                                           input logic endb);
        int                           n;
        logic [acr_pkg::SLOT_W-1:0]   dest;
        logic [acr_pkg::SAMPLE_W-1:0] msk;
        out_word_t                    w;
        begin
            // copy mode: sample goes straight out
            if (sh_pass || !sh_remap)
            begin
                w.smp  = smp;
                w.last = 1'b1;
                expected_words.push_back(w);
                if (endb)
                    clear_frame();
                return;
            end
            // unsupported size: nothing out, frame only cleared by buffer end
            if (sh_size > acr_pkg::SZ_32)
            begin
                if (endb)
                    clear_frame();
                return;
            end
            msk  = (sh_size == acr_pkg::SZ_32) ? '1 :
                   (32'd1 << (8 * (sh_size + 1))) - 32'd1;
            n    = active_channels();
            dest = sh_map[3 * chan_pos +: 3];
            if (dest < n)
            begin
                frame_slots[dest] = smp & msk;
                slot_filled[dest] = 1'b1;
            end
            if (int'(chan_pos) + 1 >= n)
            begin
                for (int k = 0; k < n; k++)
                begin
                    w.smp  = slot_filled[k] ? frame_slots[k] : '0;
                    w.last = (k == n - 1);
                    expected_words.push_back(w);
                end
                clear_frame();
            end
            else if (endb)
            begin
                clear_frame();
            end
            else
            begin
                chan_pos = chan_pos + 1'b1;
            end
        end
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [acr_pkg::SAMPLE_W-1:0] got,
                                   input logic [acr_pkg::SAMPLE_W-1:0] want);
        begin
            $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
            err_count++;
        end
    endtask

    // Register write, then shadow update
    task automatic write_reg(input logic [acr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [acr_pkg::CFG_W-1:0] data);
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= data;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            case (idx)
                acr_pkg::REG_REMAP_ENABLE:  sh_remap = data[0];
                acr_pkg::REG_PASSTHROUGH:   sh_pass  = data[0];
                acr_pkg::REG_SAMPLE_SIZE:   sh_size  = data[2:0];
                acr_pkg::REG_CHANNEL_COUNT: sh_count = data[acr_pkg::COUNT_W-1:0];
                acr_pkg::REG_CHANNEL_MAP:   sh_map   = data;
                default: ;
            endcase
            @(posedge clk);
        end
    endtask

    task automatic write_setting(input logic remap, input logic pass, input logic [2:0] size,
                                 input logic [acr_pkg::COUNT_W-1:0] count,
                                 input logic [acr_pkg::CFG_W-1:0] map);
        begin
            write_reg(acr_pkg::REG_REMAP_ENABLE, acr_pkg::CFG_W'(remap));
            write_reg(acr_pkg::REG_PASSTHROUGH, acr_pkg::CFG_W'(pass));
            write_reg(acr_pkg::REG_SAMPLE_SIZE, acr_pkg::CFG_W'(size));
            write_reg(acr_pkg::REG_CHANNEL_COUNT, acr_pkg::CFG_W'(count));
            write_reg(acr_pkg::REG_CHANNEL_MAP, map);
        end
    endtask

    // One input transaction, with an optional random gap before it
    task automatic send_sample(input logic [acr_pkg::SAMPLE_W-1:0] smp, input logic endb);
        int gap;
        begin
            gap = 0;
            while ($urandom_range(0, 99) < send_idle_pct)
                gap++;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= smp;
            s_tlast  <= endb;
            do
                @(posedge clk);
            while (!s_tready);
        end
    endtask

    // Drop valid, let every expected word arrive, then let the block settle
    task automatic wait_idle();
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (expected_words.size() != 0)
                @(posedge clk);
            repeat (DRAIN_GUARD) @(posedge clk);
        end
    endtask

    // Random register setting; unused upper data bits carry junk
    task automatic apply_random_setting();
        logic [acr_pkg::SLOT_W-1:0] perm [MAX_CH];
        logic [acr_pkg::SLOT_W-1:0] tmp;
        logic [acr_pkg::CFG_W-1:0]  m;
        logic [acr_pkg::CFG_W-1:0]  junk;
        int                         pick;
        int                         j;
        begin
            wait_idle();
            junk = acr_pkg::CFG_W'($urandom);
            write_reg(acr_pkg::REG_REMAP_ENABLE,
                      {junk[acr_pkg::CFG_W-1:1], ($urandom_range(0, 99) < 85)});
            junk = acr_pkg::CFG_W'($urandom);
            write_reg(acr_pkg::REG_PASSTHROUGH,
                      {junk[acr_pkg::CFG_W-1:1], ($urandom_range(0, 99) < 15)});
            junk = acr_pkg::CFG_W'($urandom);
            pick = ($urandom_range(0, 99) < 10) ? $urandom_range(4, 7) : $urandom_range(0, 3);
            write_reg(acr_pkg::REG_SAMPLE_SIZE, {junk[acr_pkg::CFG_W-1:3], 3'(pick)});
            junk = acr_pkg::CFG_W'($urandom);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                pick = 0;
            else if (pick == 1)
                pick = $urandom_range(MAX_CH + 1, 15);
            else
                pick = $urandom_range(1, MAX_CH);
            write_reg(acr_pkg::REG_CHANNEL_COUNT,
                      {junk[acr_pkg::CFG_W-1:acr_pkg::COUNT_W], acr_pkg::COUNT_W'(pick)});
            // map: random bits, a permutation, or a codec layout
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                m = acr_pkg::CFG_W'($urandom);
            end
            else if (pick < 8)
            begin
                for (int k = 0; k < MAX_CH; k++)
                    perm[k] = acr_pkg::SLOT_W'(k);
                for (int k = MAX_CH - 1; k > 0; k--)
                begin
                    j       = $urandom_range(0, k);
                    tmp     = perm[k];
                    perm[k] = perm[j];
                    perm[j] = tmp;
                end
                for (int k = 0; k < MAX_CH; k++)
                    m[3 * k +: 3] = perm[k];
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       m = MAP_6CH_A;
                    1:       m = MAP_6CH_B;
                    2:       m = MAP_6CH_C;
                    default: m = MAP_5CH;
                endcase
            end
            write_reg(acr_pkg::REG_CHANNEL_MAP, m);
        end
    endtask

    // Mostly whole frames; some cut short by a buffer end
    task automatic send_random_frames(input int budget);
        int   n;
        int   len;
        logic endb;
        begin
            n = active_channels();
            while (budget > 0)
            begin
                len = ($urandom_range(0, 99) < 12) ? $urandom_range(1, n) : n;
                for (int k = 0; k < len; k++)
                begin
                    if (len < n)
                        endb = (k == len - 1);
                    else
                        endb = (k == len - 1) && ($urandom_range(0, 3) == 0);
                    send_sample($urandom, endb);
                end
                budget -= len;
            end
        end
    endtask

    // ---------------- directed tests ----------------

    // Reset state is copy mode
    task automatic test_copy_after_reset();
        begin
            wait_idle();
            send_sample(32'h0000_0000, 1'b0);
            send_sample(32'hFFFF_FFFF, 1'b1);
        end
    endtask

    // Remap with reset size, count and identity map
    task automatic test_remap_reset_values();
        begin
            wait_idle();
            write_reg(acr_pkg::REG_REMAP_ENABLE, acr_pkg::CFG_W'(1));
            send_sample(32'hFFFF_FFFF, 1'b0);
            send_sample($urandom, 1'b1);
        end
    endtask

    // Two channels to one slot, one channel past the count, 8-bit mask
    task automatic test_duplicate_and_dropped_slots();
        begin
            wait_idle();
            write_setting(1'b1, 1'b0, acr_pkg::SZ_8, 4'd3,
                          {3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd5, 3'd1, 3'd1});
            send_sample($urandom, 1'b0);
            send_sample(32'hFFFF_FFFF, 1'b0);
            send_sample($urandom, 1'b0);
        end
    endtask

    // Buffer end in mid-frame discards it
    task automatic test_partial_frame_drop();
        begin
            wait_idle();
            write_setting(1'b1, 1'b0, acr_pkg::SZ_24, 4'd2, acr_pkg::CHANNEL_MAP_RST);
            send_sample(32'hFFFF_FFFF, 1'b1);
            send_sample($urandom, 1'b0);
            send_sample(32'hFFFF_FFFF, 1'b1);
        end
    endtask

    // Count zero acts as one, count above the maximum saturates
    task automatic test_count_clamping();
        begin
            wait_idle();
            write_setting(1'b1, 1'b0, acr_pkg::SZ_16, 4'd0, 24'h00_0000);
            send_sample(32'hFFFF_FFFF, 1'b0);
            wait_idle();
            write_setting(1'b1, 1'b0, acr_pkg::SZ_32, 4'd9, 24'hFF_FFFF);
            for (int k = 0; k < MAX_CH; k++)
                send_sample($urandom, 1'b0);
        end
    endtask

    // Unsupported size leaves a partial frame alone
    task automatic test_unsupported_size();
        begin
            wait_idle();
            write_setting(1'b1, 1'b0, acr_pkg::SZ_32, 4'd2, acr_pkg::CHANNEL_MAP_RST);
            send_sample($urandom, 1'b0);
            wait_idle();
            write_reg(acr_pkg::REG_SAMPLE_SIZE, acr_pkg::CFG_W'(SZ_UNSUPPORTED));
            send_sample($urandom, 1'b0);
            wait_idle();
            write_reg(acr_pkg::REG_SAMPLE_SIZE, acr_pkg::CFG_W'(acr_pkg::SZ_32));
            send_sample($urandom, 1'b0);
        end
    endtask

    // Count shrinks below the position of a partial frame
    task automatic test_count_shrink_mid_frame();
        begin
            wait_idle();
            write_setting(1'b1, 1'b0, acr_pkg::SZ_8, 4'd3, acr_pkg::CHANNEL_MAP_RST);
            send_sample($urandom, 1'b0);
            send_sample($urandom, 1'b0);
            wait_idle();
            write_reg(acr_pkg::REG_CHANNEL_COUNT, acr_pkg::CFG_W'(1));
            send_sample($urandom, 1'b0);
        end
    endtask

    // Copy mode between samples of a frame; unused indexes change nothing
    task automatic test_copy_mid_frame();
        begin
            wait_idle();
            write_setting(1'b1, 1'b0, acr_pkg::SZ_16, 4'd2, acr_pkg::CHANNEL_MAP_RST);
            send_sample($urandom, 1'b0);
            wait_idle();
            write_reg(acr_pkg::REG_PASSTHROUGH, acr_pkg::CFG_W'(1));
            send_sample($urandom, 1'b0);
            wait_idle();
            write_reg(acr_pkg::REG_PASSTHROUGH, acr_pkg::CFG_W'(0));
            send_sample($urandom, 1'b0);
            wait_idle();
            for (int k = acr_pkg::REG_CHANNEL_MAP + 1; k < (1 << acr_pkg::CFG_IDX_W); k++)
                write_reg(acr_pkg::CFG_IDX_W'(k), acr_pkg::CFG_W'($urandom));
            send_sample($urandom, 1'b0);
            send_sample($urandom, 1'b1);
        end
    endtask

    // ---------------- random tests ----------------

    task automatic test_random_traffic(input int items);
        int sent;
        int chunk;
        begin
            sent = 0;
            while (sent < items)
            begin
                apply_random_setting();
                chunk = $urandom_range(6, 30);
                send_random_frames(chunk);
                sent += chunk;
            end
        end
    endtask

    // Sink holds off for a long stretch while frames keep coming
    task automatic test_output_backpressure();
        begin
            wait_idle();
            write_setting(1'b1, 1'b0, acr_pkg::SZ_32, 4'd8, MAP_6CH_C);
            stall_requests <= stall_requests + 1;
            send_random_frames(5 * MAX_CH);
        end
    endtask

    // Sink: random m_tready, plus long hold-offs on request
    initial
    begin : sink
        int hold;
        int served;
        hold   = 0;
        served = 0;
        forever
        begin
            @(posedge clk);
            if (served != stall_requests)
            begin
                served = stall_requests;
                hold   = LONG_STALL;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Scoreboard: predict on input transactions, compare output transactions,
    // and stop the run when nothing moves for too long
    initial
    begin : scoreboard
        int        quiet;
        out_word_t want;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n)
            begin
                quiet++;
                if (m_tvalid && m_tready)
                begin
                    quiet = 0;
                    if (expected_words.size() == 0)
                    begin
                        report_mismatch("unexpected output", m_tdata, '0);
                    end
                    else
                    begin
                        want = expected_words.pop_front();
                        if (m_tdata !== want.smp)
                            report_mismatch("out_sample", m_tdata, want.smp);
                        if (m_tlast !== want.last)
                            report_mismatch("frame_last", acr_pkg::SAMPLE_W'(m_tlast),
                                            acr_pkg::SAMPLE_W'(want.last));
                    end
                end
                if (s_tvalid && s_tready)
                begin
                    quiet = 0;
                    predict_sample(s_tdata, s_tlast);
                end
            end
        end
        $display("[%0t] watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Test sequence
    initial
    begin : main_seq
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_idle_pct = 12;
        recv_idle_pct <= 80;
        test_copy_after_reset();
        test_remap_reset_values();
        test_duplicate_and_dropped_slots();
        test_partial_frame_drop();
        test_count_clamping();
        test_unsupported_size();
        test_count_shrink_mid_frame();
        test_copy_mid_frame();
        test_random_traffic(120);

        send_idle_pct = 80;
        recv_idle_pct <= 12;
        test_random_traffic(120);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        test_output_backpressure();
        test_random_traffic(80);

        wait_idle();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
